/* hdl/msbpd_pkg.sv */
// types and constants shared by the press detector modules
// no dependencies
package msbpd_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CAL_SAMPLES  = 16;
    localparam int SAMPLE_BITS  = 10;

    // fixed field widths
    localparam int CHANNEL_W = 3;
    localparam int SENS_W    = 16;
    localparam int CIU_W     = 4;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int CAL_CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int CAL_SUM_W = SAMPLE_BITS + $clog2(CAL_SAMPLES + 1);
    localparam int PROD_W    = SENS_W + SAMPLE_BITS;
    localparam int NUM_CH_W  = $clog2(NUM_CHANNELS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(6554);
    localparam logic [CIU_W-1:0]  CIU_RESET  = CIU_W'(8);

    typedef enum logic [0:0] {
        REG_SENSITIVITY     = 1'b0,
        REG_CHANNELS_IN_USE = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_CALIBRATE,
        OP_MEASURE
    } op_t;

    typedef struct packed {
        logic                   mode;
        logic [CHANNEL_W-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                   channel_pressed;
        logic                   frame_done;
        logic                   all_pressed;
        logic                   reference_written;
        logic [SAMPLE_BITS-1:0] reference_value;
    } out_item_t;

    // classified command handed from the front to the back
    typedef struct packed {
        op_t                    op;
        logic [CHANNEL_W-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   in_frame;
        logic                   frame_last;
    } cmd_t;

    typedef struct packed {
        logic [SENS_W-1:0] sensitivity;
        logic [CIU_W-1:0]  channels_in_use;
    } cfg_t;

    localparam logic MODE_CALIBRATE = 1'b0;

endpackage

/* hdl/msbpd_front.sv */
// front stage: accepts input beats, classifies them and holds one command
// depends on msbpd_pkg
module msbpd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  msbpd_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  msbpd_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output msbpd_pkg::cmd_t   cmd
);
    import msbpd_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    cmd_t       stage_reg;
    cmd_t       stage_next;
    logic [CIU_W-1:0] n_eff;
    logic [CIU_W-1:0] ch_wide;
    logic       accept;

    // clamp channels in use to 1 .. NUM_CHANNELS
    always_comb
    begin
        n_eff = cfg.channels_in_use;
        if (n_eff == '0)
        begin
            n_eff = CIU_W'(1);
        end
        if (n_eff > CIU_W'(NUM_CHANNELS))
        begin
            n_eff = CIU_W'(NUM_CHANNELS);
        end
    end

    assign ch_wide = CIU_W'(in_data.channel);

    always_comb
    begin
        stage_next.channel    = in_data.channel;
        stage_next.sample     = in_data.sample;
        stage_next.in_frame   = (ch_wide < n_eff);
        stage_next.frame_last = (ch_wide == n_eff - CIU_W'(1));
        if (ch_wide >= CIU_W'(NUM_CHANNELS))
        begin
            stage_next.op = OP_IGNORE;
        end
        else if (in_data.mode == MODE_CALIBRATE)
        begin
            stage_next.op = OP_CALIBRATE;
        end
        else
        begin
            stage_next.op = OP_MEASURE;
        end
    end

    assign in_ready  = !stage_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

/* hdl/msbpd_queue.sv */
// short command queue between front and back
// depends on msbpd_pkg
module msbpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  msbpd_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output msbpd_pkg::cmd_t pop_cmd
);
    import msbpd_pkg::*;

    cmd_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/msbpd_back.sv */
// back stage: calibration accumulator, reference table, threshold test,
// frame and, and the output register
// depends on msbpd_pkg
module msbpd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msbpd_pkg::cfg_t      cfg,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  msbpd_pkg::cmd_t      cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output msbpd_pkg::out_item_t out_data
);
    import msbpd_pkg::*;

    logic [SAMPLE_BITS-1:0] ref_table_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] ref_new;
    logic                   ref_we;
    logic [CAL_SUM_W-1:0]   cal_sum_reg;
    logic [CAL_SUM_W-1:0]   cal_sum_next;
    logic [CAL_SUM_W-1:0]   cal_sum_inc;
    logic [CAL_CNT_W-1:0]   cal_cnt_reg;
    logic [CAL_CNT_W-1:0]   cal_cnt_next;
    logic [CAL_CNT_W:0]     cal_cnt_inc;
    logic                   frame_ok_reg;
    logic                   frame_ok_next;
    logic                   frame_ok_and;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_reg;
    out_item_t              out_next;
    logic [SAMPLE_BITS-1:0] ref_cur;
    logic [SAMPLE_BITS-1:0] diff;
    logic [PROD_W-1:0]      lhs;
    logic [PROD_W-1:0]      rhs;
    logic                   pressed;
    logic                   take;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign ref_cur = ref_table_reg[cmd.channel];

    // deviation * 2^16 against sensitivity * reference
    assign diff    = (ref_cur >= cmd.sample) ? ref_cur - cmd.sample : cmd.sample - ref_cur;
    assign lhs     = {diff, SENS_W'(0)};
    assign rhs     = PROD_W'(cfg.sensitivity) * PROD_W'(ref_cur);
    assign pressed = (lhs >= rhs);

    assign cal_sum_inc  = cal_sum_reg + CAL_SUM_W'(cmd.sample);
    assign cal_cnt_inc  = {1'b0, cal_cnt_reg} + 1'b1;
    assign frame_ok_and = frame_ok_reg && pressed;

    always_comb
    begin
        cal_sum_next   = cal_sum_reg;
        cal_cnt_next   = cal_cnt_reg;
        frame_ok_next  = frame_ok_reg;
        ref_we         = 1'b0;
        ref_new        = SAMPLE_BITS'(cal_sum_inc / CAL_SAMPLES);
        out_next       = '0;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            case (cmd.op)
                OP_CALIBRATE:
                begin
                    out_next.reference_value = ref_cur;
                    if (cal_cnt_inc >= (CAL_CNT_W + 1)'(CAL_SAMPLES))
                    begin
                        ref_we                     = 1'b1;
                        cal_sum_next               = '0;
                        cal_cnt_next               = '0;
                        out_next.reference_written = 1'b1;
                        out_next.reference_value   = ref_new;
                    end
                    else
                    begin
                        cal_sum_next = cal_sum_inc;
                        cal_cnt_next = cal_cnt_inc[CAL_CNT_W-1:0];
                    end
                end
                OP_MEASURE:
                begin
                    out_next.channel_pressed = pressed;
                    out_next.reference_value = ref_cur;
                    if (cmd.in_frame)
                    begin
                        if (cmd.frame_last)
                        begin
                            out_next.frame_done  = 1'b1;
                            out_next.all_pressed = frame_ok_and;
                            frame_ok_next        = 1'b1;
                        end
                        else
                        begin
                            frame_ok_next = frame_ok_and;
                        end
                    end
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg   <= '0;
            cal_cnt_reg   <= '0;
            frame_ok_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ref_table_reg[i] <= '0;
            end
        end
        else
        begin
            cal_sum_reg   <= cal_sum_next;
            cal_cnt_reg   <= cal_cnt_next;
            frame_ok_reg  <= frame_ok_next;
            out_valid_reg <= out_valid_next;
            if (ref_we)
            begin
                ref_table_reg[cmd.channel] <= ref_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* hdl/multi_sensor_baseline_press_detect.sv */
// top level of the baseline calibrated press detector
// depends on msbpd_pkg, msbpd_front, msbpd_queue, msbpd_back
//
// each input beat is one adc sample tagged with a channel and a mode. calibration
// beats (mode 0) are summed; every CAL_SAMPLES of them the floored mean becomes the
// reference of the channel carried by the finishing beat, and reference_written is
// set on that result. measurement beats (mode 1) report channel_pressed when
// |reference - sample| * 65536 >= sensitivity * reference, so a zero reference is
// always pressed. pressed flags of the channels in use are and-ed over a frame and
// all_pressed comes out with frame_done on the last channel in use. exactly one
// result beat leaves for every input beat, in order. throughput is one beat per
// clock sustained while out_ready is held high; a beat passes through the front
// register, a queue entry and the output register in that order. the back stage
// computes the 16 x 10 bit multiply and compare of the threshold test
// combinationally. the two-entry queue lets the front keep taking beats while the
// output is stalled, until the queue and the front register are full.
// configuration writes should only be made while the block holds no beat.
module multi_sensor_baseline_press_detect (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  msbpd_pkg::cfg_index_t           cfg_index,
    input  logic [msbpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  msbpd_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output msbpd_pkg::out_item_t            out_data
);
    import msbpd_pkg::*;

    // configuration registers
    logic [SENS_W-1:0] sensitivity_reg;
    logic [SENS_W-1:0] sensitivity_next;
    logic [CIU_W-1:0]  channels_in_use_reg;
    logic [CIU_W-1:0]  channels_in_use_next;
    cfg_t              cfg;

    // front to queue
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;

    // queue to back
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    always_comb
    begin
        sensitivity_next     = sensitivity_reg;
        channels_in_use_next = channels_in_use_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SENSITIVITY:     sensitivity_next     = cfg_data[SENS_W-1:0];
                REG_CHANNELS_IN_USE: channels_in_use_next = cfg_data[CIU_W-1:0];
                default:             sensitivity_next     = sensitivity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensitivity_reg     <= SENS_RESET;
            channels_in_use_reg <= CIU_RESET;
        end
        else
        begin
            sensitivity_reg     <= sensitivity_next;
            channels_in_use_reg <= channels_in_use_next;
        end
    end

    assign cfg.sensitivity     = sensitivity_reg;
    assign cfg.channels_in_use = channels_in_use_reg;

    // classify beats: ignore out-of-table channels, tag frame membership
    msbpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    // decouples front acceptance from back stalls
    msbpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // state update, threshold test and registered result
    msbpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
